[rtl/idst_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Identifier table package
// Shared constants, codes, control structures and character tests.
// ----------------------------------------------------------------------------
package idst_pkg;

    localparam int MAX_WORDS_DEF = 512;
    localparam int MAX_LEN_DEF   = 64;

    localparam int CHAR_W   = 8;
    localparam int IDX_W    = 9;
    localparam int COUNT_W  = 10;
    localparam int STATUS_W = 3;

    localparam logic [CHAR_W-1:0] UNDERSCORE = 8'h5F;

    typedef enum logic [1:0] {
        CMD_TEXT  = 2'd0,
        CMD_END   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    localparam logic [STATUS_W-1:0] ST_NONE      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd4;

    typedef enum logic [1:0] {
        RSEL_IDX,
        RSEL_SCAN,
        RSEL_SHIFT
    } rank_rsel_t;

    typedef struct packed {
        logic                ld_in;
        logic                tok_append;
        logic                tok_clear;
        logic                tbl_clear;
        logic                cnt_inc;
        logic                i_clr;
        logic                i_inc;
        logic                j_clr;
        logic                j_inc;
        logic                k_load;
        logic                k_dec;
        logic                rank_re;
        rank_rsel_t          rank_rsel;
        logic                rank_we;
        logic                rank_w_new;
        logic                slot_ld;
        logic                len_re;
        logic                wlen_ld;
        logic                len_we;
        logic                tok_re;
        logic                word_re;
        logic                word_we;
        logic                res_set;
        logic [STATUS_W-1:0] res_status;
        logic                res_trunc;
        logic                out_load;
        logic                out_from_word;
    } dp_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic is_ident;
        logic tok_empty;
        logic tok_digits;
        logic idx_bad;
        logic i_at_count;
        logic j_at_tok;
        logic j_at_end;
        logic len_eq;
        logic len_lt;
        logic char_eq;
        logic char_lt;
        logic full;
        logic k_at_i;
        logic rd_last;
        logic out_free;
    } dp_stat_t;

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_ident(input logic [CHAR_W-1:0] c);
        return (c == UNDERSCORE) || is_digit(c) ||
               ((c >= 8'h41) && (c <= 8'h5A)) ||
               ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

endpackage

[rtl/idst_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module idst_ram #(
    parameter int WIDTH = idst_pkg::CHAR_W,
    parameter int DEPTH = idst_pkg::MAX_LEN_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/idst_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Identifier table controller
// Sequences token append, table search, insertion, read-out and clearing.
// ----------------------------------------------------------------------------
module idst_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  idst_pkg::dp_stat_t st,
    output idst_pkg::dp_cmd_t  ctl
);
    import idst_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE,
        S_SCAN_RANK, S_SCAN_SLOT, S_SCAN_LEN, S_SCAN_RD, S_SCAN_CMP,
        S_DECIDE, S_COPY_RD, S_COPY_WR, S_LEN_WR, S_SHIFT_RD, S_SHIFT_WR,
        S_RD_SLOT, S_RD_LEN, S_RD_CHAR, S_RD_OUT, S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   dup_reg, dup_next;
    logic   finish;

    assign item_ready = (state_reg == S_IDLE);
    assign finish     = (st.cmd == CMD_END) || ((st.cmd == CMD_TEXT) && !st.is_ident);

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        dup_next   = dup_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    ctl.ld_in  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority if ((st.cmd == CMD_TEXT) && st.is_ident)
                begin
                    ctl.tok_append = 1'b1;
                    ctl.res_set    = 1'b1;
                    ctl.res_status = ST_NONE;
                    state_next     = S_EMIT;
                end
                else if (finish)
                begin
                    if (st.tok_empty)
                    begin
                        ctl.res_set    = 1'b1;
                        ctl.res_status = ST_NONE;
                        ctl.res_trunc  = 1'b1;
                        ctl.tok_clear  = 1'b1;
                        state_next     = S_EMIT;
                    end
                    else
                    begin
                        ctl.i_clr  = 1'b1;
                        dup_next   = 1'b0;
                        state_next = S_SCAN_RANK;
                    end
                end
                else if (st.cmd == CMD_READ)
                begin
                    if (st.idx_bad)
                    begin
                        ctl.res_set    = 1'b1;
                        ctl.res_status = ST_BAD_INDEX;
                        state_next     = S_EMIT;
                    end
                    else
                    begin
                        ctl.rank_re   = 1'b1;
                        ctl.rank_rsel = RSEL_IDX;
                        state_next    = S_RD_SLOT;
                    end
                end
                else
                begin
                    ctl.tbl_clear  = 1'b1;
                    ctl.tok_clear  = 1'b1;
                    ctl.res_set    = 1'b1;
                    ctl.res_status = ST_NONE;
                    state_next     = S_EMIT;
                end
            end
            S_SCAN_RANK:
            begin
                if (st.i_at_count)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    ctl.rank_re   = 1'b1;
                    ctl.rank_rsel = RSEL_SCAN;
                    state_next    = S_SCAN_SLOT;
                end
            end
            S_SCAN_SLOT:
            begin
                ctl.slot_ld = 1'b1;
                ctl.len_re  = 1'b1;
                ctl.j_clr   = 1'b1;
                state_next  = S_SCAN_LEN;
            end
            S_SCAN_LEN:
            begin
                ctl.wlen_ld = 1'b1;
                state_next  = S_SCAN_RD;
            end
            S_SCAN_RD:
            begin
                priority if (st.j_at_end && st.len_eq)
                begin
                    dup_next   = 1'b1;
                    state_next = S_DECIDE;
                end
                else if (st.j_at_end && st.len_lt)
                begin
                    state_next = S_DECIDE;
                end
                else if (st.j_at_end)
                begin
                    ctl.i_inc  = 1'b1;
                    state_next = S_SCAN_RANK;
                end
                else
                begin
                    ctl.tok_re  = 1'b1;
                    ctl.word_re = 1'b1;
                    state_next  = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP:
            begin
                priority if (st.char_eq)
                begin
                    ctl.j_inc  = 1'b1;
                    state_next = S_SCAN_RD;
                end
                else if (st.char_lt)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    ctl.i_inc  = 1'b1;
                    state_next = S_SCAN_RANK;
                end
            end
            S_DECIDE:
            begin
                priority if (st.tok_digits || dup_reg)
                begin
                    ctl.res_set    = 1'b1;
                    ctl.res_status = ST_IGNORED;
                    ctl.res_trunc  = 1'b1;
                    ctl.tok_clear  = 1'b1;
                    state_next     = S_EMIT;
                end
                else if (st.full)
                begin
                    ctl.res_set    = 1'b1;
                    ctl.res_status = ST_FULL;
                    ctl.res_trunc  = 1'b1;
                    ctl.tok_clear  = 1'b1;
                    state_next     = S_EMIT;
                end
                else
                begin
                    ctl.j_clr  = 1'b1;
                    state_next = S_COPY_RD;
                end
            end
            S_COPY_RD:
            begin
                if (st.j_at_tok)
                begin
                    state_next = S_LEN_WR;
                end
                else
                begin
                    ctl.tok_re = 1'b1;
                    state_next = S_COPY_WR;
                end
            end
            S_COPY_WR:
            begin
                ctl.word_we = 1'b1;
                ctl.j_inc   = 1'b1;
                state_next  = S_COPY_RD;
            end
            S_LEN_WR:
            begin
                ctl.len_we = 1'b1;
                ctl.k_load = 1'b1;
                state_next = S_SHIFT_RD;
            end
            S_SHIFT_RD:
            begin
                if (st.k_at_i)
                begin
                    ctl.rank_we    = 1'b1;
                    ctl.rank_w_new = 1'b1;
                    ctl.cnt_inc    = 1'b1;
                    ctl.res_set    = 1'b1;
                    ctl.res_status = ST_ADDED;
                    ctl.res_trunc  = 1'b1;
                    ctl.tok_clear  = 1'b1;
                    state_next     = S_EMIT;
                end
                else
                begin
                    ctl.rank_re   = 1'b1;
                    ctl.rank_rsel = RSEL_SHIFT;
                    state_next    = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                ctl.rank_we = 1'b1;
                ctl.k_dec   = 1'b1;
                state_next  = S_SHIFT_RD;
            end
            S_RD_SLOT:
            begin
                ctl.slot_ld = 1'b1;
                ctl.len_re  = 1'b1;
                ctl.j_clr   = 1'b1;
                state_next  = S_RD_LEN;
            end
            S_RD_LEN:
            begin
                ctl.wlen_ld = 1'b1;
                state_next  = S_RD_CHAR;
            end
            S_RD_CHAR:
            begin
                ctl.word_re = 1'b1;
                state_next  = S_RD_OUT;
            end
            S_RD_OUT:
            begin
                if (st.out_free)
                begin
                    ctl.out_load      = 1'b1;
                    ctl.out_from_word = 1'b1;
                    if (st.rd_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ctl.j_inc  = 1'b1;
                        state_next = S_RD_CHAR;
                    end
                end
            end
            S_EMIT:
            begin
                if (st.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            dup_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            dup_reg   <= dup_next;
        end
    end

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> st.out_free)
        else $error("Result register loaded while still occupied.");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> (state_reg == S_DECODE))
        else $error("Accepted transfer not decoded.");

    a_dup_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE && dup_reg) |=> (state_reg == S_EMIT))
        else $error("Duplicate token was not dropped.");

endmodule

[rtl/idst_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Identifier table datapath
// Token buffer, entry store, rank list, counters and result register.
// ----------------------------------------------------------------------------
module idst_datapath #(
    parameter int MAX_WORDS = idst_pkg::MAX_WORDS_DEF,
    parameter int MAX_LEN   = idst_pkg::MAX_LEN_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [1:0]                       cmd,
    input  logic [idst_pkg::CHAR_W-1:0]      text_byte,
    input  logic [idst_pkg::IDX_W-1:0]       entry_index,
    input  idst_pkg::dp_cmd_t                ctl,
    output idst_pkg::dp_stat_t               st,
    output logic                             result_valid,
    input  logic                             result_ready,
    output logic [idst_pkg::CHAR_W-1:0]      out_char,
    output logic                             last,
    output logic [idst_pkg::COUNT_W-1:0]     entry_count,
    output logic [idst_pkg::STATUS_W-1:0]    status,
    output logic                             truncated
);
    import idst_pkg::*;

    localparam int SW  = $clog2(MAX_WORDS);
    localparam int CW  = $clog2(MAX_WORDS + 1);
    localparam int LW  = $clog2(MAX_LEN + 1);
    localparam int TW  = $clog2(MAX_LEN);
    localparam int WD  = MAX_WORDS * MAX_LEN;
    localparam int WAW = $clog2(WD);
    localparam int IXW = (CW > IDX_W) ? CW : IDX_W;

    cmd_t                cmd_reg;
    logic [CHAR_W-1:0]   byte_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [CW-1:0]       count_reg;
    logic [LW-1:0]       tok_len_reg;
    logic                tok_digits_reg;
    logic                tok_ovf_reg;
    logic [CW-1:0]       i_reg;
    logic [LW-1:0]       j_reg;
    logic [CW-1:0]       k_reg;
    logic [SW-1:0]       slot_reg;
    logic [LW-1:0]       wlen_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic                res_trunc_reg;
    logic                result_valid_reg;
    logic [CHAR_W-1:0]   out_char_reg;
    logic                last_reg;
    logic [COUNT_W-1:0]  entry_count_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                truncated_reg;

    logic [CW-1:0]       k_prev;
    logic [SW-1:0]       rank_raddr;
    logic [SW-1:0]       rank_waddr;
    logic [SW-1:0]       rank_wdata;
    logic [SW-1:0]       rank_rdata;
    logic [LW-1:0]       len_rdata;
    logic                tok_we;
    logic [CHAR_W-1:0]   tok_rdata;
    logic [WAW-1:0]      word_raddr;
    logic [WAW-1:0]      word_waddr;
    logic [CHAR_W-1:0]   word_rdata;

    assign k_prev = k_reg - 1'b1;

    always_comb
    begin
        unique case (ctl.rank_rsel)
            RSEL_IDX:   rank_raddr = SW'(idx_reg);
            RSEL_SCAN:  rank_raddr = i_reg[SW-1:0];
            RSEL_SHIFT: rank_raddr = k_prev[SW-1:0];
            default:    rank_raddr = i_reg[SW-1:0];
        endcase
    end

    assign rank_waddr = ctl.rank_w_new ? i_reg[SW-1:0] : k_reg[SW-1:0];
    assign rank_wdata = ctl.rank_w_new ? count_reg[SW-1:0] : rank_rdata;
    assign tok_we     = ctl.tok_append && (tok_len_reg != LW'(MAX_LEN));
    assign word_raddr = WAW'(slot_reg) * WAW'(MAX_LEN) + WAW'(j_reg);
    assign word_waddr = WAW'(count_reg[SW-1:0]) * WAW'(MAX_LEN) + WAW'(j_reg);

    idst_ram #(.WIDTH(SW), .DEPTH(MAX_WORDS)) u_rank_ram (
        .clk   (clk),
        .we    (ctl.rank_we),
        .waddr (rank_waddr),
        .wdata (rank_wdata),
        .re    (ctl.rank_re),
        .raddr (rank_raddr),
        .rdata (rank_rdata)
    );

    idst_ram #(.WIDTH(LW), .DEPTH(MAX_WORDS)) u_len_ram (
        .clk   (clk),
        .we    (ctl.len_we),
        .waddr (count_reg[SW-1:0]),
        .wdata (tok_len_reg),
        .re    (ctl.len_re),
        .raddr (rank_rdata),
        .rdata (len_rdata)
    );

    idst_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_tok_ram (
        .clk   (clk),
        .we    (tok_we),
        .waddr (tok_len_reg[TW-1:0]),
        .wdata (byte_reg),
        .re    (ctl.tok_re),
        .raddr (j_reg[TW-1:0]),
        .rdata (tok_rdata)
    );

    idst_ram #(.WIDTH(CHAR_W), .DEPTH(WD)) u_word_ram (
        .clk   (clk),
        .we    (ctl.word_we),
        .waddr (word_waddr),
        .wdata (tok_rdata),
        .re    (ctl.word_re),
        .raddr (word_raddr),
        .rdata (word_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            tok_len_reg      <= '0;
            tok_digits_reg   <= 1'b1;
            tok_ovf_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.tbl_clear)
            begin
                count_reg <= '0;
            end
            else if (ctl.cnt_inc)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (ctl.tok_clear)
            begin
                tok_len_reg    <= '0;
                tok_digits_reg <= 1'b1;
                tok_ovf_reg    <= 1'b0;
            end
            else if (ctl.tok_append)
            begin
                if (tok_len_reg == LW'(MAX_LEN))
                begin
                    tok_ovf_reg <= 1'b1;
                end
                else
                begin
                    tok_len_reg <= tok_len_reg + 1'b1;
                end
                if (!is_digit(byte_reg))
                begin
                    tok_digits_reg <= 1'b0;
                end
            end
            if (ctl.out_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld_in)
        begin
            cmd_reg  <= cmd_t'(cmd);
            byte_reg <= text_byte;
            idx_reg  <= entry_index;
        end
        if (ctl.i_clr)
        begin
            i_reg <= '0;
        end
        else if (ctl.i_inc)
        begin
            i_reg <= i_reg + 1'b1;
        end
        if (ctl.j_clr)
        begin
            j_reg <= '0;
        end
        else if (ctl.j_inc)
        begin
            j_reg <= j_reg + 1'b1;
        end
        if (ctl.k_load)
        begin
            k_reg <= count_reg;
        end
        else if (ctl.k_dec)
        begin
            k_reg <= k_prev;
        end
        if (ctl.slot_ld)
        begin
            slot_reg <= rank_rdata;
        end
        if (ctl.wlen_ld)
        begin
            wlen_reg <= len_rdata;
        end
        if (ctl.res_set)
        begin
            res_status_reg <= ctl.res_status;
            res_trunc_reg  <= ctl.res_trunc & tok_ovf_reg;
        end
        if (ctl.out_load)
        begin
            out_char_reg    <= ctl.out_from_word ? word_rdata : '0;
            last_reg        <= ctl.out_from_word ? st.rd_last : 1'b1;
            entry_count_reg <= COUNT_W'(count_reg);
            status_reg      <= ctl.out_from_word ? ST_NONE : res_status_reg;
            truncated_reg   <= ctl.out_from_word ? 1'b0 : res_trunc_reg;
        end
    end

    always_comb
    begin
        st.cmd        = cmd_reg;
        st.is_ident   = is_ident(byte_reg);
        st.tok_empty  = (tok_len_reg == '0);
        st.tok_digits = tok_digits_reg;
        st.idx_bad    = IXW'(idx_reg) >= IXW'(count_reg);
        st.i_at_count = (i_reg == count_reg);
        st.j_at_tok   = (j_reg == tok_len_reg);
        st.j_at_end   = (j_reg == tok_len_reg) || (j_reg == wlen_reg);
        st.len_eq     = (tok_len_reg == wlen_reg);
        st.len_lt     = (tok_len_reg < wlen_reg);
        st.char_eq    = (tok_rdata == word_rdata);
        st.char_lt    = (tok_rdata < word_rdata);
        st.full       = (count_reg == CW'(MAX_WORDS));
        st.k_at_i     = (k_reg == i_reg);
        st.rd_last    = ((j_reg + 1'b1) == wlen_reg);
        st.out_free   = !result_valid_reg || result_ready;
    end

    assign result_valid = result_valid_reg;
    assign out_char     = out_char_reg;
    assign last         = last_reg;
    assign entry_count  = entry_count_reg;
    assign status       = status_reg;
    assign truncated    = truncated_reg;

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_WORDS))
        else $error("Entry count beyond table size.");

    a_ovf_len: assert property (@(posedge clk) disable iff (!rst_n)
        tok_ovf_reg |-> (tok_len_reg == LW'(MAX_LEN)))
        else $error("Overflow flag set on a short token.");

    a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.cnt_inc |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("Entry count did not follow an insertion.");

endmodule

[rtl/identifier_dedupe_sort_table_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Identifier table with duplicate removal and sorted read-out
// Splits byte text into identifier tokens, keeps unique tokens ranked in
// byte-wise order and returns a ranked entry one character per transfer.
//
//   Channel   Handshake                   Payload
//   item      item_valid / item_ready     cmd, text_byte, entry_index
//   result    result_valid / result_ready out_char, last, entry_count,
//                                         status, truncated
//
// One item at a time. Finishing a token walks the rank list, comparing the
// token character by character with each entry passed, then stores its
// characters and shifts the later entries of the rank list up by one,
// all limited by single-port reads of the entry memory.
// Tokens made only of digits are ignored, as duplicates are.
// No clearing pass is needed after reset; result stalls hold the sequencer.
// ----------------------------------------------------------------------------
module identifier_dedupe_sort_table_unit #(
    parameter int MAX_WORDS = idst_pkg::MAX_WORDS_DEF,
    parameter int MAX_LEN   = idst_pkg::MAX_LEN_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic [1:0]                    cmd,
    input  logic [idst_pkg::CHAR_W-1:0]   text_byte,
    input  logic [idst_pkg::IDX_W-1:0]    entry_index,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [idst_pkg::CHAR_W-1:0]   out_char,
    output logic                          last,
    output logic [idst_pkg::COUNT_W-1:0]  entry_count,
    output logic [idst_pkg::STATUS_W-1:0] status,
    output logic                          truncated
);
    import idst_pkg::*;

    dp_cmd_t  ctl;
    dp_stat_t st;

    idst_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .st         (st),
        .ctl        (ctl)
    );

    idst_datapath #(.MAX_WORDS(MAX_WORDS), .MAX_LEN(MAX_LEN)) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .text_byte    (text_byte),
        .entry_index  (entry_index),
        .ctl          (ctl),
        .st           (st),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_char     (out_char),
        .last         (last),
        .entry_count  (entry_count),
        .status       (status),
        .truncated    (truncated)
    );

endmodule

[bench/identifier_dedupe_sort_table_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Identifier table unit testbench
// Feeds text bytes, end-of-text, read and clear commands through a bursty
// driver, predicts every result transfer with an independent table model and
// checks each accepted transfer field by field in a stalling monitor.
// ----------------------------------------------------------------------------
module identifier_dedupe_sort_table_unit_tb;
    import idst_pkg::*;

    localparam int NWORDS = 512;
    localparam int NLEN   = 64;

    typedef struct {
        cmd_t       cmd;
        logic [7:0] text;
        logic [8:0] idx;
        bit         drain;
    } item_t;

    typedef struct {
        logic [7:0] ch;
        logic       lst;
        logic [9:0] cnt;
        logic [2:0] st;
        logic       tr;
    } res_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       item_valid = 1'b0;
    logic       item_ready;
    logic [1:0] cmd = 2'd0;
    logic [7:0] text_byte = 8'd0;
    logic [8:0] entry_index = 9'd0;
    logic       result_valid;
    logic       result_ready = 1'b0;
    logic [7:0] out_char;
    logic       last;
    logic [9:0] entry_count;
    logic [2:0] status;
    logic       truncated;

    identifier_dedupe_sort_table_unit u_top (.*);

    always #1 clk = ~clk;

    item_t pending_items[$];
    res_t  expected_results[$];

    logic [7:0] tbl_chars[NWORDS][NLEN];
    int         tbl_len[NWORDS];
    int         rank_slot[NWORDS];
    int         tbl_count;
    logic [7:0] tok_chars[NLEN];
    int         tok_len;
    bit         tok_digits;
    bit         tok_over;

    int errors, n_items, n_results, n_added, n_full, n_reads, n_trunc;

    function automatic bit ident_char(logic [7:0] c);
        return c == 8'h5F || (c >= "0" && c <= "9") ||
               (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic int compare_token(int s);
        int m;
        m = tok_len < tbl_len[s] ? tok_len : tbl_len[s];
        for (int i = 0; i < m; i++)
            if (tok_chars[i] != tbl_chars[s][i])
                return tok_chars[i] < tbl_chars[s][i] ? -1 : 1;
        if (tok_len == tbl_len[s]) return 0;
        return tok_len < tbl_len[s] ? -1 : 1;
    endfunction

    task automatic push_result(logic [7:0] ch, logic lst, logic [2:0] st, logic tr);
        res_t r;
        r.ch = ch; r.lst = lst; r.cnt = tbl_count[9:0]; r.st = st; r.tr = tr;
        expected_results.push_back(r);
    endtask

    task automatic finish_token();
        logic [2:0] st;
        bit tr, dup;
        int pos, c;
        st = ST_NONE; tr = 0; dup = 0; pos = 0;
        if (tok_len != 0) begin
            tr = tok_over;
            if (tr) n_trunc++;
            for (int i = 0; i < tbl_count; i++) begin
                c = compare_token(rank_slot[i]);
                if (c == 0) dup = 1;
                if (c > 0) pos = i + 1;
            end
            if (tok_digits || dup) st = ST_IGNORED;
            else if (tbl_count >= NWORDS) begin
                st = ST_FULL;
                n_full++;
            end
            else begin
                for (int i = 0; i < tok_len; i++) tbl_chars[tbl_count][i] = tok_chars[i];
                tbl_len[tbl_count] = tok_len;
                for (int i = tbl_count; i > pos; i--) rank_slot[i] = rank_slot[i-1];
                rank_slot[pos] = tbl_count;
                tbl_count++;
                st = ST_ADDED;
                n_added++;
            end
        end
        tok_len = 0; tok_digits = 1; tok_over = 0;
        push_result(8'd0, 1'b1, st, tr);
    endtask

    task automatic predict_item(item_t it);
        int s;
        case (it.cmd)
            CMD_TEXT: begin
                if (!ident_char(it.text)) finish_token();
                else begin
                    if (tok_len < NLEN) begin
                        tok_chars[tok_len] = it.text;
                        tok_len++;
                    end
                    else tok_over = 1;
                    if (!(it.text >= "0" && it.text <= "9")) tok_digits = 0;
                    push_result(8'd0, 1'b1, ST_NONE, 1'b0);
                end
            end
            CMD_END: finish_token();
            CMD_READ: begin
                n_reads++;
                if (it.idx >= tbl_count) push_result(8'd0, 1'b1, ST_BAD_INDEX, 1'b0);
                else begin
                    s = rank_slot[it.idx];
                    for (int i = 0; i < tbl_len[s]; i++)
                        push_result(tbl_chars[s][i], i + 1 == tbl_len[s], ST_NONE, 1'b0);
                end
            end
            default: begin
                tbl_count = 0;
                tok_len = 0; tok_digits = 1; tok_over = 0;
                push_result(8'd0, 1'b1, ST_NONE, 1'b0);
            end
        endcase
    endtask

    // Driver: bursts of transfers separated by random gaps.
    item_t cur_item;
    int    burst_left = 1;
    int    gap_left = 0;

    always @(posedge clk) begin
        bit busy;
        if (rst_n) begin
            busy = item_valid;
            if (item_valid && item_ready) begin
                predict_item(cur_item);
                n_items++;
                busy = 0;
            end
            if (!busy) begin
                if (gap_left > 0) gap_left--;
                else if (pending_items.size() > 0) begin
                    if (pending_items[0].drain) begin
                        if (expected_results.size() == 0) void'(pending_items.pop_front());
                    end
                    else begin
                        cur_item = pending_items.pop_front();
                        cmd <= cur_item.cmd;
                        text_byte <= cur_item.text;
                        entry_index <= cur_item.idx;
                        busy = 1;
                        burst_left--;
                        if (burst_left <= 0) begin
                            burst_left = $urandom_range(1, 30);
                            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                        end
                    end
                end
            end
            item_valid <= busy;
        end
    end

    // Monitor: stalls on a pattern of its own, with one long hold-off.
    int hold_left = 0;
    int stall_phase = 0;
    bit held_once = 0;

    always @(posedge clk) begin
        res_t e;
        if (rst_n) begin
            if (result_valid && result_ready) begin
                n_results++;
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result char %h status %0d", $time,
                             out_char, status);
                end
                else begin
                    e = expected_results.pop_front();
                    if (out_char !== e.ch || last !== e.lst || entry_count !== e.cnt ||
                        status !== e.st || truncated !== e.tr) begin
                        errors++;
                        $display("%0t: expected char %h last %b count %0d status %0d trunc %b",
                                 $time, e.ch, e.lst, e.cnt, e.st, e.tr);
                        $display("%0t: actual   char %h last %b count %0d status %0d trunc %b",
                                 $time, out_char, last, entry_count, status, truncated);
                    end
                end
            end
            if (!held_once && n_results >= 150) begin
                held_once = 1;
                hold_left = 400;
            end
            stall_phase = (stall_phase + 1) % 256;
            if (hold_left > 0) begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (stall_phase < 64) result_ready <= 1'b1;
            else if (stall_phase < 160) result_ready <= ($urandom_range(0, 3) != 0);
            else result_ready <= ((stall_phase % 7) != 3) && ($urandom_range(0, 1) == 1);
        end
    end

    task automatic add_item(cmd_t c, logic [7:0] t, logic [8:0] i);
        item_t it;
        it.cmd = c; it.text = t; it.idx = i; it.drain = 0;
        pending_items.push_back(it);
    endtask

    function automatic logic [7:0] any_ident();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (!ident_char(c));
        return c;
    endfunction

    function automatic logic [7:0] any_separator();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (ident_char(c));
        return c;
    endfunction

    task automatic add_separator();
        if ($urandom_range(0, 3) == 0) add_item(CMD_END, 8'($urandom), 9'($urandom));
        else add_item(CMD_TEXT, any_separator(), 9'($urandom));
    endtask

    string alnum = "ABCDEFGHIJKLMNOPQRSTUVWXYZ_abcdefghijklmnopqrstuvwxyz0123456789";
    string few   = "aAbB_z19";

    initial begin
        item_t d;
        int len, r;
        errors = 0; n_items = 0; n_results = 0; n_added = 0;
        n_full = 0; n_reads = 0; n_trunc = 0;
        tbl_count = 0; tok_len = 0; tok_digits = 1; tok_over = 0;

        // Directed part.
        add_item(CMD_END, 8'h00, 9'h000);
        add_item(CMD_READ, 8'h00, 9'h1FF);
        add_item(CMD_TEXT, "z", 9'h000);
        add_item(CMD_TEXT, "_", 9'h000);
        add_item(CMD_TEXT, "9", 9'h000);
        add_item(CMD_TEXT, 8'hFF, 9'h1FF);
        add_item(CMD_TEXT, "0", 9'h000);
        add_item(CMD_TEXT, "7", 9'h000);
        add_item(CMD_TEXT, 8'h00, 9'h000);
        add_item(CMD_TEXT, "z", 9'h000);
        add_item(CMD_TEXT, "_", 9'h000);
        add_item(CMD_TEXT, "9", 9'h000);
        add_item(CMD_END, 8'hFF, 9'h000);
        add_item(CMD_TEXT, "A", 9'h000);
        add_item(CMD_TEXT, "z", 9'h000);
        add_item(CMD_TEXT, "{", 9'h000);
        for (int i = 0; i < 70; i++) add_item(CMD_TEXT, "q", 9'h000);
        add_item(CMD_END, 8'h00, 9'h000);
        add_item(CMD_READ, 8'h00, 9'h000);
        add_item(CMD_READ, 8'h00, 9'h002);
        add_item(CMD_READ, 8'h00, 9'h003);
        add_item(CMD_TEXT, "k", 9'h000);
        add_item(CMD_CLEAR, 8'h00, 9'h000);
        add_item(CMD_READ, 8'h00, 9'h000);
        add_item(CMD_READ, 8'h00, 9'h1FF);
        add_item(CMD_TEXT, alnum[0], 9'h000);
        add_item(CMD_TEXT, alnum[0], 9'h000);
        add_item(CMD_END, 8'h00, 9'h000);
        d.cmd = CMD_TEXT; d.text = 0; d.idx = 0; d.drain = 1;
        pending_items.push_back(d);
        add_item(CMD_CLEAR, 8'h00, 9'h000);

        // Random part: mostly well-formed tokens with random content.
        for (int n = 0; n < 320; ) begin
            r = $urandom_range(0, 39);
            if (r < 24) begin
                len = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 70)
                                                  : $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    if (r < 3)
                        add_item(CMD_TEXT, alnum[$urandom_range(53, 62)], 9'($urandom));
                    else if (r < 14)
                        add_item(CMD_TEXT, few[$urandom_range(0, 7)], 9'($urandom));
                    else add_item(CMD_TEXT, any_ident(), 9'($urandom));
                end
                add_separator();
                n += len + 1;
            end
            else if (r < 33) begin
                add_item(CMD_READ, 8'($urandom),
                         ($urandom_range(0, 4) == 0) ? 9'($urandom_range(0, 511))
                                                     : 9'($urandom_range(0, 15)));
                n++;
            end
            else if (r < 39) begin
                add_item(CMD_TEXT, 8'($urandom), 9'($urandom));
                n++;
            end
            else begin
                add_item(CMD_CLEAR, 8'($urandom), 9'($urandom));
                n++;
            end
        end
        add_item(CMD_END, 8'h00, 9'h000);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_items.size() == 0 && !item_valid && expected_results.size() == 0);
        repeat (300) @(posedge clk);
        $display("Covered %0d items, %0d result transfers, %0d reads.", n_items, n_results,
                 n_reads);
        $display("Stored %0d tokens, %0d refused when full, %0d truncated.", n_added, n_full,
                 n_trunc);
        if (errors == 0 && expected_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #20000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
